/* design/mrc_pkg.sv */
// Package with the shared types and constants of the cell index converter.
`default_nettype none
package mrc_pkg;

  localparam int ID_W       = 31;
  localparam int DIG_W      = 15;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int NREG_DIMS  = 4;
  // Quotient bits retired per pipeline stage and stages per divided digit.
  localparam int DIV_BITS   = 4;
  localparam int QUO_W      = ID_W + 1;
  localparam int DIV_STAGES = QUO_W / DIV_BITS;
  localparam int REM_W      = DIG_W + 1;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_ID2COORD = 2'd0,
    MODE_COORD2ID = 2'd1,
    MODE_NEXT     = 2'd2,
    MODE_NOP      = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_WRAP  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_NUM_DIMS   = 3'd0,
    REG_DIM_SIZE_0 = 3'd1,
    REG_DIM_SIZE_1 = 3'd2,
    REG_DIM_SIZE_2 = 3'd3,
    REG_DIM_SIZE_3 = 3'd4,
    REG_FIRST_CELL = 3'd5
  } reg_idx_e;

  typedef logic [NREG_DIMS-1:0][DIG_W-1:0] digits_t;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [2:0]      num_dims;
    digits_t         dim_size;
    logic [ID_W-1:0] first_cell;
  } cfg_t;

  // Payload carried from stage to stage.
  typedef struct packed {
    mode_e            mode;
    logic [QUO_W-1:0] quo;
    logic [REM_W-1:0] rem;
    logic [ID_W-1:0]  acc;
    digits_t          cin;
    digits_t          res;
    logic             range_err;
    logic             wrap;
  } pipe_t;

endpackage
`default_nettype wire

/* design/mrc_in_if.sv */
// Handshake interfaces for the input and result channels.
`default_nettype none
interface mrc_in_if;
  logic                          valid;
  logic                          ready;
  logic [mrc_pkg::MODE_W-1:0]    mode;
  logic [mrc_pkg::ID_W-1:0]      cell_id_in;
  logic [mrc_pkg::DIG_W-1:0]     coord_in_0;
  logic [mrc_pkg::DIG_W-1:0]     coord_in_1;
  logic [mrc_pkg::DIG_W-1:0]     coord_in_2;
  logic [mrc_pkg::DIG_W-1:0]     coord_in_3;

  modport source (output valid, mode, cell_id_in, coord_in_0, coord_in_1, coord_in_2,
                  coord_in_3, input ready);
  modport sink (input valid, mode, cell_id_in, coord_in_0, coord_in_1, coord_in_2,
                coord_in_3, output ready);
endinterface

interface mrc_out_if;
  logic                          valid;
  logic                          ready;
  logic [mrc_pkg::ID_W-1:0]      cell_id_out;
  logic [mrc_pkg::DIG_W-1:0]     coord_out_0;
  logic [mrc_pkg::DIG_W-1:0]     coord_out_1;
  logic [mrc_pkg::DIG_W-1:0]     coord_out_2;
  logic [mrc_pkg::DIG_W-1:0]     coord_out_3;
  logic [mrc_pkg::STATUS_W-1:0]  status;

  modport source (output valid, cell_id_out, coord_out_0, coord_out_1, coord_out_2,
                  coord_out_3, status, input ready);
  modport sink (input valid, cell_id_out, coord_out_0, coord_out_1, coord_out_2,
                coord_out_3, status, output ready);
endinterface
`default_nettype wire

/* design/mrc_cfg_regs.sv */
// APB configuration registers of the cell index converter.
`default_nettype none
module mrc_cfg_regs
  import mrc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register writes on the access beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_dims   <= '0;
      cfg_q.dim_size   <= {NREG_DIMS{DIG_W'(1)}};
      cfg_q.first_cell <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_NUM_DIMS:   cfg_q.num_dims    <= pwdata[2:0];
        REG_DIM_SIZE_0: cfg_q.dim_size[0] <= pwdata[DIG_W-1:0];
        REG_DIM_SIZE_1: cfg_q.dim_size[1] <= pwdata[DIG_W-1:0];
        REG_DIM_SIZE_2: cfg_q.dim_size[2] <= pwdata[DIG_W-1:0];
        REG_DIM_SIZE_3: cfg_q.dim_size[3] <= pwdata[DIG_W-1:0];
        REG_FIRST_CELL: cfg_q.first_cell  <= pwdata[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    case (idx)
      REG_NUM_DIMS:   prdata = DATA_W'(cfg_q.num_dims);
      REG_DIM_SIZE_0: prdata = DATA_W'(cfg_q.dim_size[0]);
      REG_DIM_SIZE_1: prdata = DATA_W'(cfg_q.dim_size[1]);
      REG_DIM_SIZE_2: prdata = DATA_W'(cfg_q.dim_size[2]);
      REG_DIM_SIZE_3: prdata = DATA_W'(cfg_q.dim_size[3]);
      REG_FIRST_CELL: prdata = DATA_W'(cfg_q.first_cell);
      default:        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* design/mrc_stage.sv */
// Pipe stage: DIV_BITS restoring division steps; Horner step if SUB==0, GROUP>0.
`default_nettype none
module mrc_stage
  import mrc_pkg::*;
#(
  parameter int NDIM  = 4,
  parameter int GROUP = 0,
  parameter int SUB   = 0
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       adv_i,
  input  cfg_t            cfg_i,
  input  wire logic [2:0] n_used_i,
  input  wire logic       valid_i,
  input  pipe_t           data_i,
  output logic            valid_o,
  output pipe_t           data_o
);

  localparam int HK = NDIM - 1 - GROUP;

  logic             valid_q;
  pipe_t            data_q;
  pipe_t            data_d;
  logic [DIG_W-1:0] divisor;
  logic [REM_W-1:0] r;
  logic [QUO_W-1:0] q;
  logic [ID_W+DIG_W-1:0] prod;

  // Dimensions past the used count divide by one, which leaves the value alone.
  assign divisor = (3'(GROUP) < n_used_i) ? cfg_i.dim_size[GROUP] : DIG_W'(1);
  assign prod    = cfg_i.dim_size[HK] * data_i.acc;

  always_comb begin
    data_d = data_i;
    r = (SUB == 0) ? '0 : data_i.rem;
    q = data_i.quo;
    for (int j = 0; j < DIV_BITS; j++) begin
      r = {r[REM_W-2:0], q[QUO_W-1]};
      q = {q[QUO_W-2:0], 1'b0};
      if (r >= {1'b0, divisor}) begin
        r    = r - {1'b0, divisor};
        q[0] = 1'b1;
      end
    end
    data_d.rem = r;
    data_d.quo = q;
    // The remainder of the last step is this dimension's digit.
    if (SUB == DIV_STAGES - 1 && data_i.mode == MODE_ID2COORD) begin
      data_d.res[GROUP] = r[DIG_W-1:0];
    end
    // Horner step: acc = coord[k] + size[k] * acc, modulo the id width.
    if (SUB == 0 && GROUP > 0) begin
      data_d.acc = prod[ID_W-1:0] + ID_W'(data_i.cin[HK]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

/* design/mixed_radix_cell_index_converter.sv */
// Top level of the mixed-radix cell index converter.
//
//   channel   dir  handshake            payload
//   in_i      in   valid/ready          mode, cell_id_in, coord_in_0..3
//   out_o     out  valid/ready          cell_id_out, coord_out_0..3, status
//   apb       in   psel/penable/pready  paddr, pwdata, prdata
//
// One beat enters per cycle unless the output stalls. Between front and output
// registers, the id split retires four quotient bits per stage per dimension.
// Reset clears all valid bits and loads the register reset values.
// A stall on the output freezes the whole pipeline; nothing is dropped.
`default_nettype none
module mixed_radix_cell_index_converter
  import mrc_pkg::*;
#(
  parameter int MAX_DIMS = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  mrc_in_if.sink                 in_i,
  mrc_out_if.source              out_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  localparam int NDIM = (MAX_DIMS < NREG_DIMS) ? MAX_DIMS : NREG_DIMS;
  localparam int NSTG = NDIM * DIV_STAGES;

  cfg_t       cfg;
  logic [2:0] n_used;
  logic       adv;
  logic       v   [NSTG+1];
  pipe_t      p   [NSTG+1];

  mrc_cfg_regs u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  assign n_used = (cfg.num_dims > 3'(NDIM)) ? 3'(NDIM) : cfg.num_dims;

  // The pipeline moves whenever the output register is free or being drained.
  logic out_valid_q;
  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // Front stage: offset subtract, masking, odometer step.
  pipe_t            front_d;
  digits_t          craw;
  logic [ID_W:0]    rel;
  logic             carry;
  logic             zero_sz;
  logic [DIG_W:0]   inc;

  assign craw = {in_i.coord_in_3, in_i.coord_in_2, in_i.coord_in_1, in_i.coord_in_0};

  always_comb begin
    front_d      = '0;
    front_d.mode = mode_e'(in_i.mode);
    rel          = {1'b0, in_i.cell_id_in} - {1'b0, cfg.first_cell};
    zero_sz      = 1'b0;
    carry        = 1'b1;
    inc          = '0;
    for (int i = 0; i < NREG_DIMS; i++) begin
      if (3'(i) < n_used) begin
        front_d.cin[i] = craw[i];
        if (cfg.dim_size[i] == '0) zero_sz = 1'b1;
      end
    end
    // Odometer with dimension 0 fastest.
    for (int i = 0; i < NREG_DIMS; i++) begin
      inc = {1'b0, craw[i]} + (DIG_W+1)'(1);
      if (3'(i) < n_used) begin
        if (carry) begin
          if (inc < {1'b0, cfg.dim_size[i]}) begin
            front_d.res[i] = inc[DIG_W-1:0];
            carry          = 1'b0;
          end
        end else begin
          front_d.res[i] = craw[i];
        end
      end
    end
    if (front_d.mode != MODE_NEXT) front_d.res = '0;
    front_d.wrap      = carry;
    front_d.range_err = rel[ID_W] | zero_sz;
    front_d.quo       = {1'b0, rel[ID_W-1:0]};
    front_d.acc       = ID_W'(front_d.cin[NDIM-1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p[0] <= front_d;
    end
  end

  // Division and Horner stages, DIV_STAGES per dimension.
  for (genvar g = 0; g < NDIM; g++) begin : g_dim
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_sub
      mrc_stage #(.NDIM(NDIM), .GROUP(g), .SUB(s)) u_stage (
        .clk_i, .rst_ni,
        .adv_i    (adv),
        .cfg_i    (cfg),
        .n_used_i (n_used),
        .valid_i  (v[g*DIV_STAGES+s]),
        .data_i   (p[g*DIV_STAGES+s]),
        .valid_o  (v[g*DIV_STAGES+s+1]),
        .data_o   (p[g*DIV_STAGES+s+1])
      );
    end
  end

  // Output register: status and final selection per mode.
  pipe_t            last;
  logic [ID_W-1:0]  id_d;
  digits_t          co_d;
  status_e          st_d;
  logic [ID_W-1:0]  id_q;
  digits_t          co_q;
  status_e          st_q;

  assign last = p[NSTG];

  always_comb begin
    id_d = '0;
    co_d = '0;
    st_d = ST_OK;
    case (last.mode)
      MODE_ID2COORD: begin
        if (last.range_err || last.quo != '0) begin
          st_d = ST_RANGE;
        end else begin
          co_d = last.res;
        end
      end
      MODE_COORD2ID: id_d = last.acc + cfg.first_cell;
      MODE_NEXT: begin
        co_d = last.res;
        st_d = last.wrap ? ST_WRAP : ST_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      id_q <= id_d;
      co_q <= co_d;
      st_q <= st_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.cell_id_out = id_q;
  assign out_o.coord_out_0 = co_q[0];
  assign out_o.coord_out_1 = co_q[1];
  assign out_o.coord_out_2 = co_q[2];
  assign out_o.coord_out_3 = co_q[3];
  assign out_o.status      = st_q;

endmodule
`default_nettype wire

/* test/mixed_radix_cell_index_converter_tb.sv */
// Self-checking testbench for the mixed-radix cell index converter.
`default_nettype none
module mixed_radix_cell_index_converter_tb;
  import mrc_pkg::*;

  // One converted grid location as seen on the result channel.
  typedef struct packed {
    logic [ID_W-1:0]     id;
    digits_t             crd;
    logic [STATUS_W-1:0] st;
  } cell_res_t;

  // Holds the grid setup, predicts each conversion and checks the results.
  class conv_board;
    logic [2:0]      ndims;
    logic [14:0]     sizes [4];
    logic [30:0]     base;
    cell_res_t       pending [$];
    int              errors;
    int              checked;

    function void clear_grid();
      ndims = 0;
      base = 0;
      foreach (sizes[k]) sizes[k] = 1;
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] v);
      case (idx)
        REG_NUM_DIMS:   ndims = v[2:0];
        REG_DIM_SIZE_0: sizes[0] = v[14:0];
        REG_DIM_SIZE_1: sizes[1] = v[14:0];
        REG_DIM_SIZE_2: sizes[2] = v[14:0];
        REG_DIM_SIZE_3: sizes[3] = v[14:0];
        REG_FIRST_CELL: base = v[30:0];
        default: ;
      endcase
    endfunction

    // Works out the result of one accepted beat.
    function void note_input(mode_e md, logic [30:0] cid, digits_t cin);
      cell_res_t r;
      int unsigned n;
      longint unsigned total, rel, fac, acc;
      bit carry;
      r = '0;
      n = (ndims > 4) ? 4 : ndims;
      case (md)
        MODE_ID2COORD: begin
          total = 1;
          for (int k = 0; k < n; k++) total *= sizes[k];
          if (cid < base || longint'(cid - base) >= total) begin
            r.st = ST_RANGE;
          end else begin
            rel = cid - base;
            for (int k = 0; k < n; k++) begin
              r.crd[k] = rel % sizes[k];
              rel = rel / sizes[k];
            end
          end
        end
        MODE_COORD2ID: begin
          fac = 1;
          acc = 0;
          for (int k = 0; k < n; k++) begin
            acc += fac * cin[k];
            fac *= sizes[k];
          end
          r.id = acc + base;
        end
        MODE_NEXT: begin
          carry = 1;
          for (int k = 0; k < n; k++) begin
            if (carry) begin
              if (longint'(cin[k]) + 1 < sizes[k]) begin
                r.crd[k] = cin[k] + 1;
                carry = 0;
              end
            end else begin
              r.crd[k] = cin[k];
            end
          end
          if (carry) r.st = ST_WRAP;
        end
        default: ;
      endcase
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(cell_res_t got);
      cell_res_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.id !== exp_r.id) begin
        $display("%0t: cell_id_out expected %h actual %h", $time, exp_r.id, got.id);
        errors++;
      end
      for (int k = 0; k < 4; k++)
        if (got.crd[k] !== exp_r.crd[k]) begin
          $display("%0t: coord_out_%0d expected %h actual %h", $time, k,
                   exp_r.crd[k], got.crd[k]);
          errors++;
        end
      if (got.st !== exp_r.st) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.st, got.st);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY = 34;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  longint cycles = 0;
  bit draining = 0;

  mrc_in_if  in_ch ();
  mrc_out_if out_ch ();
  conv_board board;

  mixed_radix_cell_index_converter i_dut (
    .clk_i, .rst_ni, .in_i(in_ch.sink), .out_o(out_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 0;
    in_ch.mode = '0;
    in_ch.cell_id_in = '0;
    in_ch.coord_in_0 = '0;
    in_ch.coord_in_1 = '0;
    in_ch.coord_in_2 = '0;
    in_ch.coord_in_3 = '0;
    out_ch.ready = 0;
  end

  // Cycle counter with a hard stop.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("mixed_radix_cell_index_converter_tb: done, errors");
      $finish;
    end
  end

  // Result side: stall at random, then sample each accepted beat.
  initial begin
    int gap;
    board = new();
    board.clear_grid();
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (draining || $urandom_range(0, 4) == 0) gap = 0;
      if (gap != 0) begin
        out_ch.ready <= 0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1;
      do @(posedge clk_i); while (!out_ch.valid);
      board.check_result({out_ch.cell_id_out, out_ch.coord_out_3, out_ch.coord_out_2,
                          out_ch.coord_out_1, out_ch.coord_out_0, out_ch.status});
    end
  end

  // One APB write; the select stays high so writes can follow back to back.
  task automatic write_reg(reg_idx_e idx, logic [31:0] v);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= ADDR_W'(4 * idx);
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    board.set_reg(idx, v);
  endtask

  task automatic set_grid(int nd, int s0, int s1, int s2, int s3, logic [30:0] b);
    write_reg(REG_NUM_DIMS, nd);
    write_reg(REG_DIM_SIZE_0, s0);
    write_reg(REG_DIM_SIZE_1, s1);
    write_reg(REG_DIM_SIZE_2, s2);
    write_reg(REG_DIM_SIZE_3, s3);
    write_reg(REG_FIRST_CELL, b);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  // Sends one beat, then idles for a random gap unless nogap is set.
  task automatic send_beat(mode_e md, logic [30:0] cid, digits_t cin, bit nogap);
    int gap;
    in_ch.valid <= 1;
    in_ch.mode <= md;
    in_ch.cell_id_in <= cid;
    in_ch.coord_in_0 <= cin[0];
    in_ch.coord_in_1 <= cin[1];
    in_ch.coord_in_2 <= cin[2];
    in_ch.coord_in_3 <= cin[3];
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_input(md, cid, cin);
    gap = nogap ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 0;
    draining = 1;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    draining = 0;
  endtask

  function automatic digits_t near_coord();
    digits_t c;
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(0, 5))
        0: c[k] = 15'h7fff;
        1: c[k] = board.sizes[k];
        2: c[k] = board.sizes[k] - 1;
        3: c[k] = $urandom;
        default: c[k] = (board.sizes[k] == 0) ? 0 : $urandom_range(0, board.sizes[k] - 1);
      endcase
    end
    return c;
  endfunction

  // Random beat biased toward ids inside the grid and coordinates near the edges.
  task automatic random_beat(bit burst);
    longint unsigned total;
    logic [30:0] cid;
    mode_e md;
    int n;
    n = (board.ndims > 4) ? 4 : board.ndims;
    total = 1;
    for (int k = 0; k < n; k++) total *= board.sizes[k];
    md = mode_e'($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2));
    case ($urandom_range(0, 5))
      0: cid = $urandom;
      1: cid = board.base - 1;
      2: cid = board.base + total;
      3: cid = board.base + total - 1;
      default: cid = board.base + (total == 0 ? 0 : ({$urandom, $urandom} % total));
    endcase
    send_beat(md, cid, near_coord(), burst);
  endtask

  initial begin
    digits_t z, ones;
    int nd;
    z = '0;
    ones = {4{15'h7fff}};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Reset grid: a single cell.
    send_beat(MODE_ID2COORD, 0, z, 0);
    send_beat(MODE_ID2COORD, 1, z, 0);
    send_beat(MODE_NEXT, 0, ones, 0);
    send_beat(MODE_NOP, 31'h7fffffff, ones, 0);
    wait_idle();

    // Directed corners of a full four-dimension grid.
    set_grid(4, 3, 5, 7, 2, 100);
    send_beat(MODE_ID2COORD, 99, z, 0);
    send_beat(MODE_ID2COORD, 100, z, 1);
    send_beat(MODE_ID2COORD, 100 + 209, z, 1);
    send_beat(MODE_ID2COORD, 100 + 210, z, 0);
    send_beat(MODE_COORD2ID, 0, {15'd1, 15'd6, 15'd4, 15'd2}, 0);
    send_beat(MODE_COORD2ID, 0, ones, 0);
    send_beat(MODE_NEXT, 0, {15'd1, 15'd6, 15'd4, 15'd2}, 0);
    send_beat(MODE_NEXT, 0, {15'd0, 15'd0, 15'd4, 15'd2}, 0);
    send_beat(MODE_NEXT, 0, {15'd0, 15'd2, 15'd9, 15'd0}, 0);
    send_beat(MODE_NOP, 5, ones, 0);
    wait_idle();

    // Too many dimensions, a zero size and the widest base.
    set_grid(7, 15'h7fff, 0, 15'h7fff, 15'h7fff, 31'h7fffffff);
    send_beat(MODE_ID2COORD, 31'h7fffffff, z, 0);
    send_beat(MODE_COORD2ID, 0, ones, 0);
    send_beat(MODE_NEXT, 0, {15'd3, 15'd2, 15'd0, 15'h7ffe}, 0);
    send_beat(MODE_NEXT, 0, ones, 0);
    wait_idle();
    set_grid(4, 15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff, 0);
    send_beat(MODE_ID2COORD, 31'h7fffffff, z, 0);
    send_beat(MODE_COORD2ID, 0, ones, 0);
    wait_idle();

    // Random phases over a range of grid shapes.
    for (int ph = 0; ph < 24; ph++) begin
      nd = $urandom_range(0, 7);
      case (ph % 4)
        0: set_grid(nd, $urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8),
                    $urandom_range(1, 8), $urandom_range(0, 300));
        1: set_grid(nd, $urandom_range(0, 32767), $urandom_range(0, 32767),
                    $urandom_range(0, 32767), $urandom_range(0, 32767), $urandom);
        2: set_grid(nd, $urandom_range(1, 40), $urandom_range(0, 3), $urandom_range(1, 200),
                    $urandom_range(1, 32767), 31'h7fffffff - $urandom_range(0, 1000));
        default: set_grid(nd, $urandom_range(1, 100), $urandom_range(1, 100),
                          $urandom_range(1, 100), $urandom_range(1, 100), $urandom);
      endcase
      for (int i = 0; i < 75; i++) random_beat(ph % 3 == 0);
      wait_idle();
    end

    $display("covered %0d results over 27 grid setups, every mode and edge ids",
             board.checked);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("mixed_radix_cell_index_converter_tb: done, clean");
    else
      $display("mixed_radix_cell_index_converter_tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
